// ----- rtl/keyword_framed_command_receiver_defines.svh -----
// Assertion macros for the keyword framed command receiver.
`ifndef KEYWORD_FRAMED_COMMAND_RECEIVER_DEFINES_SVH
`define KEYWORD_FRAMED_COMMAND_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF

`define KFCR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

`define KFCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define KFCR_ASSERT(lbl, clk, rst_n, prop)

`define KFCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/kfcr_pkg.sv -----
// Types, constants and helpers for the keyword framed command receiver.
package kfcr_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int FILL_W        = $clog2(MAX_KEY_BYTES + 1);
    localparam int DATA_W        = 8;
    localparam int LEN_W         = 4;
    localparam int PAT_W         = 64;
    localparam int PAT_IDX_W     = 3;
    localparam int CAP_W         = 11;
    localparam int PB_W          = 9;
    localparam int TOT_W         = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int KIND_W        = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET      = CAP_W'(264);
    localparam logic [DATA_W-1:0] MAX_PAY_RESET  = DATA_W'(255);

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_ACCEPT     = 3'd1,
        KIND_BAD_END    = 3'd2,
        KIND_OVER_LIMIT = 3'd3,
        KIND_OVERFLOW   = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LEN      = 3'd0,
        CFG_START_PATTERN  = 3'd1,
        CFG_END_LEN        = 3'd2,
        CFG_END_PATTERN    = 3'd3,
        CFG_LIMIT_MODE     = 3'd4,
        CFG_MAX_PAYLOAD    = 3'd5,
        CFG_FRAME_CAPACITY = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] length;
        logic              frame_end;
    } t_result;

    // Byte j of a keyword, first byte in the lowest octet.
    function automatic logic [DATA_W-1:0] key_byte(input logic [PAT_W-1:0] pat,
                                                   input logic [PAT_IDX_W-1:0] j);
        return pat[DATA_W*j +: DATA_W];
    endfunction

endpackage

// ----- rtl/keyword_framed_command_receiver.sv -----
// Keyword framed command receiver: start keyword hunt, length, payload, end check.
//
// Takes one received byte per cycle unless stalled and returns at most one result per
// byte. While hunting, the last start_len bytes are compared with the start keyword;
// after the match come a length byte L, L payload bytes (L = 255 means 256) and end_len
// end keyword bytes. Each payload byte comes out as a result with frame_end low unless
// it ends the frame; the last byte of a frame gives a status result (accepted, bad end,
// over limit, or overflow once frame_capacity bytes have arrived). Throughput is one
// byte per clock unless stalled, set by the per-byte update of the hunt window and frame
// counter; a taken byte is held in the input stage register and its result goes to the
// output register or skid slot. Two output slots let input keep flowing while a result
// waits, so the input stalls only when both are occupied. Registers take a write and
// apply at once, also mid-frame; write them only while no byte is held in the input stage.
`include "keyword_framed_command_receiver_defines.svh"

module keyword_framed_command_receiver (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // byte input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [kfcr_pkg::DATA_W-1:0]          i_data_in,
    // result output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [kfcr_pkg::KIND_W-1:0]          o_kind,
    output logic [kfcr_pkg::DATA_W-1:0]          o_data_out,
    output logic [kfcr_pkg::DATA_W-1:0]          o_payload_length,
    output logic                                 o_frame_end,
    // register writes
    input  logic                                 i_cfg_wr_en,
    input  logic [kfcr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kfcr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int MK = kfcr_pkg::MAX_KEY_BYTES;

    // configuration
    logic [kfcr_pkg::LEN_W-1:0]  r_start_len;
    logic [kfcr_pkg::PAT_W-1:0]  r_start_pat;
    logic [kfcr_pkg::LEN_W-1:0]  r_end_len;
    logic [kfcr_pkg::PAT_W-1:0]  r_end_pat;
    logic                        r_limit_mode;
    logic [kfcr_pkg::DATA_W-1:0] r_max_pay;
    logic [kfcr_pkg::CAP_W-1:0]  r_cap;

    // input stage
    logic                        r_in_valid;
    logic [kfcr_pkg::DATA_W-1:0] r_in_data;

    // receiver state
    logic                        r_hunting, n_hunting;
    logic [kfcr_pkg::DATA_W-1:0] r_win [MK];
    logic [kfcr_pkg::DATA_W-1:0] n_win [MK];
    logic [kfcr_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [kfcr_pkg::CAP_W-1:0]  r_cnt, n_cnt;
    logic [kfcr_pkg::DATA_W-1:0] r_len, n_len;
    logic                        r_mism, n_mism;

    // output slots
    logic                        r_out_valid;
    kfcr_pkg::t_result           r_out;
    logic                        r_skid_valid;
    kfcr_pkg::t_result           r_skid;

    logic                        s_go;
    logic                        s_pop;
    logic                        w_match;
    logic [kfcr_pkg::FILL_W-1:0] w_fill_inc;
    logic [kfcr_pkg::CAP_W-1:0]  w_n;
    logic [kfcr_pkg::DATA_W-1:0] w_len;
    logic [kfcr_pkg::PB_W-1:0]   w_pb;
    logic [kfcr_pkg::TOT_W-1:0]  w_pb1;
    logic [kfcr_pkg::TOT_W-1:0]  w_total;
    logic                        w_is_pay;
    logic                        w_in_end;
    logic [kfcr_pkg::CAP_W-1:0]  w_k;
    logic                        w_mism;
    logic                        w_done;
    logic                        w_ovf;
    logic                        w_status;
    logic                        w_has;
    kfcr_pkg::t_result           w_res;

    assign s_go       = r_in_valid && !r_skid_valid;
    assign s_pop      = r_out_valid && i_out_ready;
    assign o_in_ready = !r_in_valid || !r_skid_valid;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_len  <= '0;
            r_start_pat  <= '0;
            r_end_len    <= '0;
            r_end_pat    <= '0;
            r_limit_mode <= 1'b1;
            r_max_pay    <= kfcr_pkg::MAX_PAY_RESET;
            r_cap        <= kfcr_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            case (kfcr_pkg::t_cfg_idx'(i_cfg_index))
                kfcr_pkg::CFG_START_LEN: begin
                    r_start_len <= i_cfg_data[kfcr_pkg::LEN_W-1:0];
                end
                kfcr_pkg::CFG_START_PATTERN: begin
                    r_start_pat <= i_cfg_data;
                end
                kfcr_pkg::CFG_END_LEN: begin
                    r_end_len <= i_cfg_data[kfcr_pkg::LEN_W-1:0];
                end
                kfcr_pkg::CFG_END_PATTERN: begin
                    r_end_pat <= i_cfg_data;
                end
                kfcr_pkg::CFG_LIMIT_MODE: begin
                    r_limit_mode <= i_cfg_data[0];
                end
                kfcr_pkg::CFG_MAX_PAYLOAD: begin
                    r_max_pay <= i_cfg_data[kfcr_pkg::DATA_W-1:0];
                end
                kfcr_pkg::CFG_FRAME_CAPACITY: begin
                    r_cap <= i_cfg_data[kfcr_pkg::CAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // start keyword hunt: shifted window, compare newest start_len bytes
    always_comb begin
        logic                        all_ok;
        logic [kfcr_pkg::LEN_W-1:0]  idx;
        n_win[0] = r_in_data;
        for (int i = 1; i < MK; i++) begin
            n_win[i] = r_win[i-1];
        end
        w_fill_inc = (r_fill < kfcr_pkg::FILL_W'(MK)) ? r_fill + 1'b1 : r_fill;
        all_ok = 1'b1;
        for (int i = 0; i < MK; i++) begin
            idx = r_start_len - 1'b1 - kfcr_pkg::LEN_W'(i);
            if (kfcr_pkg::LEN_W'(i) < r_start_len &&
                n_win[i] != kfcr_pkg::key_byte(r_start_pat, idx[kfcr_pkg::PAT_IDX_W-1:0])) begin
                all_ok = 1'b0;
            end
        end
        w_match = all_ok &&
                  kfcr_pkg::CAP_W'(r_start_len) <= kfcr_pkg::CAP_W'(MK) &&
                  kfcr_pkg::CAP_W'(r_start_len) <= kfcr_pkg::CAP_W'(w_fill_inc) &&
                  kfcr_pkg::CAP_W'(r_start_len) <= r_cap;
    end

    // frame byte: position, length, end keyword check, status
    always_comb begin
        w_n      = r_cnt + 1'b1;
        w_len    = (w_n == kfcr_pkg::CAP_W'(1)) ? r_in_data : r_len;
        w_pb     = (w_len == 8'hFF) ? kfcr_pkg::PB_W'(256) : kfcr_pkg::PB_W'(w_len);
        w_pb1    = kfcr_pkg::TOT_W'(w_pb) + 1'b1;
        w_total  = w_pb1 + kfcr_pkg::TOT_W'(r_end_len);
        w_is_pay = w_n >= kfcr_pkg::CAP_W'(2) && w_n <= kfcr_pkg::CAP_W'(w_pb1);
        w_in_end = w_n > kfcr_pkg::CAP_W'(w_pb1);
        w_k      = w_n - kfcr_pkg::CAP_W'(w_pb1) - 1'b1;
        w_mism   = ((w_n == kfcr_pkg::CAP_W'(1)) ? 1'b0 : r_mism) |
                   (w_in_end && (w_k >= kfcr_pkg::CAP_W'(MK) ||
                    r_in_data != kfcr_pkg::key_byte(r_end_pat,
                                                   w_k[kfcr_pkg::PAT_IDX_W-1:0])));
        w_done   = w_n >= kfcr_pkg::CAP_W'(w_total);
        w_ovf    = w_n >= r_cap;
        w_status = !r_hunting && (w_done || w_ovf);
        w_has    = s_go && !r_hunting && (w_done || w_ovf || w_is_pay);

        w_res.data      = w_is_pay ? r_in_data : '0;
        w_res.length    = w_len;
        w_res.frame_end = w_done || w_ovf;
        if (w_done) begin
            if (w_mism || kfcr_pkg::CAP_W'(r_end_len) > kfcr_pkg::CAP_W'(MK)) begin
                w_res.kind = kfcr_pkg::KIND_BAD_END;
            end else if (r_limit_mode && w_len > r_max_pay) begin
                w_res.kind = kfcr_pkg::KIND_OVER_LIMIT;
            end else begin
                w_res.kind = kfcr_pkg::KIND_ACCEPT;
            end
        end else if (w_ovf) begin
            w_res.kind = kfcr_pkg::KIND_OVERFLOW;
        end else begin
            w_res.kind = kfcr_pkg::KIND_PAYLOAD;
        end
    end

    // next receiver state
    always_comb begin
        n_hunting = r_hunting;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_mism    = r_mism;
        if (s_go) begin
            if (r_hunting) begin
                if (w_match) begin
                    n_hunting = 1'b0;
                    n_fill    = '0;
                    n_cnt     = '0;
                end else begin
                    n_fill = w_fill_inc;
                end
            end else begin
                n_len  = w_len;
                n_mism = w_mism;
                if (w_done || w_ovf) begin
                    n_hunting = 1'b1;
                    n_fill    = '0;
                    n_cnt     = '0;
                end else begin
                    n_cnt = w_n;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_hunting    <= 1'b1;
            r_fill       <= '0;
            r_cnt        <= '0;
            r_len        <= '0;
            r_mism       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (s_go) begin
                r_in_valid <= 1'b0;
            end
            r_hunting <= n_hunting;
            r_fill    <= n_fill;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_mism    <= n_mism;
            if (!r_out_valid || s_pop) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_has;
                end
            end else if (w_has) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_data_in;
        end
        if (s_go && r_hunting) begin
            r_win <= n_win;
        end
        if (!r_out_valid || s_pop) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_has) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_data_out       = r_out.data;
    assign o_payload_length = r_out.length;
    assign o_frame_end      = r_out.frame_end;

    `KFCR_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    `KFCR_ASSERT(a_hunt_count_zero, i_clk, i_rst_n, r_hunting |-> r_cnt == '0)
    `KFCR_ASSERT_NEXT(a_status_rehunts, i_clk, i_rst_n, s_go && w_status, r_hunting)
    `KFCR_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= kfcr_pkg::FILL_W'(MK))

endmodule
